/* src/cbrf_pkg.sv */
`timescale 1ns / 1ps

package cbrf_pkg;

  // Field widths fixed by the item format
  localparam int CNT_W     = 5;
  localparam int CHUNK_MAX = 16;
  localparam int LANE_W    = 64;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_REAPING = 2'd2;

  // Input beat
  typedef struct packed {
    logic              op;
    logic [CNT_W-1:0]  byte_count;
    logic [LANE_W-1:0] data_lo;
    logic [LANE_W-1:0] data_hi;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [CNT_W-1:0]  moved_count;
    logic [LANE_W-1:0] read_lo;
    logic [LANE_W-1:0] read_hi;
    logic [1:0]        status;
    logic              reject_flag;
    logic              notify_writer;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch beat, decide length and status
    logic step;    // move one byte
    logic commit;  // update cursors and flag, present result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic moves_done;  // all bytes of this beat issued
  } dp_sts_t;

endpackage

/* src/cbrf_ram.sv */
`timescale 1ns / 1ps

module cbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/cbrf_ctrl.sv */
`timescale 1ns / 1ps

module cbrf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cbrf_pkg::dp_sts_t sts,
  output cbrf_pkg::dp_cmd_t cmd,
  output logic              busy
);

  import cbrf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   busy_r;

  // State and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            busy_r  <= 1'b1;
          end
        end
        S_RUN: begin
          if (sts.moves_done) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.step   = (state_r == S_RUN) && !sts.moves_done;
    cmd.commit = (state_r == S_FINISH);
  end

  assign busy = busy_r;

endmodule

/* src/cbrf_dp.sv */
`timescale 1ns / 1ps

module cbrf_dp #(
  parameter int RING_DEPTH = 2048,
  parameter int MAX_CHUNK  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cbrf_pkg::dp_cmd_t   cmd,
  output cbrf_pkg::dp_sts_t   sts,
  input  cbrf_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  output cbrf_pkg::out_item_t out_item,
  output logic                out_valid
);

  import cbrf_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int HW = AW + 1;

  // Architectural state
  logic [AW-1:0] rd_cur_r, wr_cur_r;
  logic          rej_r;
  logic          rw_cfg_r;

  // Per-beat working registers
  logic                op_r;
  logic [CNT_W-1:0]    len_r;
  logic [CNT_W-1:0]    idx_r;
  logic [2*LANE_W-1:0] wdata_r;
  logic [2*LANE_W-1:0] rbuf_r;
  logic [1:0]          stat_r;
  logic                rej_new_r;
  logic                notify_r;
  logic                pend_r;
  logic [3:0]          slot_r;

  // Result register
  out_item_t out_r;
  logic      out_valid_r;

  // Ring memory port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Fill level and decision logic
  logic [HW-1:0]    held, room;
  logic [CNT_W-1:0] cnt_sat, avail;
  logic [CNT_W-1:0] len_nxt;
  logic [1:0]       stat_nxt;
  logic             rej_new_nxt, notify_nxt;

  function automatic logic [AW-1:0] cur_inc(input logic [AW-1:0] c);
    cur_inc = (c == AW'(RING_DEPTH - 1)) ? '0 : c + 1'b1;
  endfunction

  always_comb begin
    if (wr_cur_r >= rd_cur_r) begin
      held = {1'b0, wr_cur_r} - {1'b0, rd_cur_r};
    end else begin
      held = {1'b0, wr_cur_r} + HW'(RING_DEPTH) - {1'b0, rd_cur_r};
    end
    room    = HW'(RING_DEPTH - 1) - held;
    cnt_sat = (in_item.byte_count > CNT_W'(MAX_CHUNK)) ? CNT_W'(MAX_CHUNK)
                                                       : in_item.byte_count;
    avail   = (held > HW'(MAX_CHUNK)) ? CNT_W'(MAX_CHUNK) : held[CNT_W-1:0];

    len_nxt     = '0;
    stat_nxt    = ST_DONE;
    rej_new_nxt = rej_r;
    notify_nxt  = 1'b0;
    if (in_item.op == OP_WRITE) begin
      if (rw_cfg_r) begin
        stat_nxt = ST_REAPING;
      end else if (room >= HW'(cnt_sat)) begin
        len_nxt     = cnt_sat;
        rej_new_nxt = 1'b0;
      end else begin
        stat_nxt    = ST_NO_ROOM;
        rej_new_nxt = 1'b1;
      end
    end else begin
      len_nxt = avail;
      if (avail != '0) begin
        rej_new_nxt = 1'b0;
        notify_nxt  = rej_r;
      end
    end
  end

  assign sts.moves_done = (idx_r == len_r);

  // Ring memory hookup: writes and reads never overlap
  assign ram_we    = cmd.step && (op_r == OP_WRITE);
  assign ram_waddr = wr_cur_r;
  assign ram_wdata = wdata_r[8*idx_r[3:0] +: 8];
  assign ram_raddr = rd_cur_r;

  cbrf_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rw_cfg_r <= 1'b0;
    end else if (cfg_we) begin
      rw_cfg_r <= cfg_wdata;
    end
  end

  // Cursors and reject flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cur_r <= '0;
      wr_cur_r <= '0;
      rej_r    <= 1'b0;
    end else begin
      if (cmd.step) begin
        if (op_r == OP_WRITE) begin
          wr_cur_r <= cur_inc(wr_cur_r);
        end else begin
          rd_cur_r <= cur_inc(rd_cur_r);
        end
      end
      if (cmd.commit) begin
        rej_r <= rej_new_r;
        // ring drained by a read: rewind both cursors
        if ((op_r == OP_READ) && (len_r != '0) && (rd_cur_r == wr_cur_r)) begin
          rd_cur_r <= '0;
          wr_cur_r <= '0;
        end
      end
    end
  end

  // Beat control: byte index and read pipeline flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.step && (op_r == OP_READ);
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Beat payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_item.op;
      len_r     <= len_nxt;
      wdata_r   <= {in_item.data_hi, in_item.data_lo};
      stat_r    <= stat_nxt;
      rej_new_r <= rej_new_nxt;
      notify_r  <= notify_nxt;
    end
    slot_r <= idx_r[3:0];
    // read data lands in the cycle after its address is presented
    if (cmd.load) begin
      rbuf_r <= '0;
    end else if (pend_r) begin
      rbuf_r[8*slot_r +: 8] <= ram_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
    if (cmd.commit) begin
      out_r.moved_count   <= len_r;
      out_r.read_lo       <= rbuf_r[LANE_W-1:0];
      out_r.read_hi       <= rbuf_r[2*LANE_W-1:LANE_W];
      out_r.status        <= stat_r;
      out_r.reject_flag   <= rej_new_r;
      out_r.notify_writer <= notify_r;
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

/* src/console_byte_ring_fifo_core.sv */
`timescale 1ns / 1ps

// Channel   Ports                          Handshake
// input     in_item (in_item_t)            beat taken when start && !busy
// result    out_item (out_item_t)          one-cycle strobe out_valid
// config    cfg_we, cfg_wdata              written when cfg_we
//
// A beat moves N bytes (N up to MAX_CHUNK), one byte per cycle through the
// byte-wide ring memory port. After the bytes come a state in which the last
// read byte lands and the count is seen complete, a drain state and a commit
// state; out_valid is registered from the commit.
// busy is high from the accept edge until the commit edge, and start is
// ignored while it is high. The next beat can be taken in the strobe cycle.
// Reset is synchronous on rst_n and needs no clearing pass of the ring.
// out_valid is high for one cycle only; the receiver cannot stall.

module console_byte_ring_fifo_core #(
  parameter int RING_DEPTH = 2048,
  parameter int MAX_CHUNK  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cbrf_pkg::in_item_t  in_item,
  output logic                out_valid,
  output cbrf_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  import cbrf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cbrf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  cbrf_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_CHUNK  (MAX_CHUNK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_refused_moves_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ST_DONE)) |-> (out_item.moved_count == '0))
    else $error("refused write reports moved bytes");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.moved_count <= CNT_W'(MAX_CHUNK)))
    else $error("moved count above chunk limit");

  a_notify_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.notify_writer) |-> !out_item.reject_flag)
    else $error("notify with reject flag still set");

endmodule
